// ===== rtl/tpt_pkg.sv =====
// Package: request and response payload types and command codes for the task priority table.
package tpt_pkg;

    localparam int ID_W    = 8;
    localparam int FIELD_W = 16;

    typedef enum logic [1:0] {
        CMD_ADD    = 2'd0,
        CMD_EDIT   = 2'd1,
        CMD_REMOVE = 2'd2,
        CMD_EXEC   = 2'd3
    } cmd_t;

    typedef struct packed {
        cmd_t                cmd;
        logic [ID_W-1:0]     task_id;
        logic [FIELD_W-1:0]  user_id;
        logic [FIELD_W-1:0]  priority_req;
    } req_t;

    typedef struct packed {
        logic                found;
        logic [FIELD_W-1:0]  owner;
    } rsp_t;

endpackage

// ===== rtl/tpt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module tpt_ram #(
    parameter int WIDTH = 33,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/task_priority_table_top.sv =====
// Top level: task table with add, edit, remove and execute-top over one shared RAM.
//
//  channel  direction  payload           handshake
//  req      in         tpt_pkg::req_t    req_valid / req_ready
//  rsp      out        tpt_pkg::rsp_t    rsp_valid / rsp_ready
//
// Add and remove write the slot when the request is taken; edit reads then writes one slot.
// Execute top: one compare unit scans every slot
// through the single RAM read port, then writes the winner back as free.
// After reset a clearing pass marks all slots free; req_ready stays low until it ends.
// One request at a time; a new request is taken while a response still waits,
// and a finished request holds until the response register is free.
module task_priority_table_top #(
    parameter int TASK_SLOTS = 256,
    parameter int PRIO_BITS  = 16,
    parameter int USER_BITS  = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    input  tpt_pkg::req_t req,
    input  logic          req_valid,
    output logic          req_ready,
    output tpt_pkg::rsp_t rsp,
    output logic          rsp_valid,
    input  logic          rsp_ready
);

    import tpt_pkg::*;

    localparam int IDX_W  = $clog2(TASK_SLOTS);
    localparam int WORD_W = 1 + USER_BITS + PRIO_BITS;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EDIT_WR,
        ST_SCAN,
        ST_SCAN_TAIL,
        ST_EXEC_WR,
        ST_RESULT
    } state_t;

    state_t               state_reg,      state_next;
    logic [IDX_W-1:0]     addr_reg,       addr_next;
    logic                 rd_pending_reg, rd_pending_next;
    logic [IDX_W-1:0]     rd_idx_reg,     rd_idx_next;
    logic                 have_reg,       have_next;
    logic [IDX_W-1:0]     best_idx_reg,   best_idx_next;
    logic [PRIO_BITS-1:0] best_prio_reg,  best_prio_next;
    logic [USER_BITS-1:0] best_owner_reg, best_owner_next;
    logic [PRIO_BITS-1:0] edit_prio_reg,  edit_prio_next;
    logic [IDX_W-1:0]     edit_idx_reg,   edit_idx_next;
    logic                 found_reg,      found_next;
    logic [FIELD_W-1:0]   owner_reg,      owner_next;
    logic                 rsp_valid_reg,  rsp_valid_next;
    rsp_t                 rsp_reg,        rsp_next;

    logic                 ram_we;
    logic [IDX_W-1:0]     ram_waddr;
    logic [WORD_W-1:0]    ram_wdata;
    logic [IDX_W-1:0]     ram_raddr;
    logic [WORD_W-1:0]    ram_rdata;

    logic                 rd_vld;
    logic [USER_BITS-1:0] rd_owner;
    logic [PRIO_BITS-1:0] rd_prio;
    logic                 accept;
    logic                 in_range;
    logic [IDX_W-1:0]     req_idx;
    logic                 take_rd;
    logic                 rsp_free;

    tpt_ram #(
        .WIDTH (WORD_W),
        .DEPTH (TASK_SLOTS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_vld   = ram_rdata[WORD_W-1];
    assign rd_owner = ram_rdata[PRIO_BITS +: USER_BITS];
    assign rd_prio  = ram_rdata[PRIO_BITS-1:0];

    assign req_ready = (state_reg == ST_IDLE);
    assign accept    = req_valid && req_ready;
    assign in_range  = (32'(req.task_id) < 32'(TASK_SLOTS));
    assign req_idx   = IDX_W'(req.task_id);
    assign rsp_free  = !rsp_valid_reg || rsp_ready;

    // shared compare unit: ties go to the later, higher slot
    assign take_rd = rd_pending_reg && rd_vld && (!have_reg || (rd_prio >= best_prio_reg));

    assign rsp       = rsp_reg;
    assign rsp_valid = rsp_valid_reg;

    always_comb
    begin
        state_next      = state_reg;
        addr_next       = addr_reg;
        rd_pending_next = 1'b0;
        rd_idx_next     = rd_idx_reg;
        have_next       = have_reg;
        best_idx_next   = best_idx_reg;
        best_prio_next  = best_prio_reg;
        best_owner_next = best_owner_reg;
        edit_prio_next  = edit_prio_reg;
        edit_idx_next   = edit_idx_reg;
        found_next      = found_reg;
        owner_next      = owner_reg;
        rsp_valid_next  = rsp_valid_reg;
        rsp_next        = rsp_reg;

        ram_we    = 1'b0;
        ram_waddr = req_idx;
        ram_wdata = {1'b1, USER_BITS'(req.user_id), PRIO_BITS'(req.priority_req)};
        ram_raddr = req_idx;

        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        if (take_rd)
        begin
            have_next       = 1'b1;
            best_idx_next   = rd_idx_reg;
            best_prio_next  = rd_prio;
            best_owner_next = rd_owner;
        end

        case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = addr_reg;
                ram_wdata = '0;
                addr_next = IDX_W'(addr_reg + 1'b1);
                if (addr_reg == IDX_W'(TASK_SLOTS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    found_next     = 1'b0;
                    owner_next     = '0;
                    edit_prio_next = PRIO_BITS'(req.priority_req);
                    edit_idx_next  = req_idx;
                    state_next     = ST_RESULT;
                    case (req.cmd)
                        CMD_ADD:
                        begin
                            ram_we = in_range;
                        end
                        CMD_EDIT:
                        begin
                            if (in_range)
                            begin
                                state_next = ST_EDIT_WR;
                            end
                        end
                        CMD_REMOVE:
                        begin
                            ram_we    = in_range;
                            ram_wdata = '0;
                        end
                        CMD_EXEC:
                        begin
                            addr_next  = '0;
                            have_next  = 1'b0;
                            state_next = ST_SCAN;
                        end
                        default:
                        begin
                            state_next = ST_RESULT;
                        end
                    endcase
                end
            end
            ST_EDIT_WR:
            begin
                ram_we     = rd_vld;
                ram_waddr  = edit_idx_reg;
                ram_wdata  = {1'b1, rd_owner, edit_prio_reg};
                state_next = ST_RESULT;
            end
            ST_SCAN:
            begin
                ram_raddr       = addr_reg;
                rd_pending_next = 1'b1;
                rd_idx_next     = addr_reg;
                addr_next       = IDX_W'(addr_reg + 1'b1);
                if (addr_reg == IDX_W'(TASK_SLOTS - 1))
                begin
                    state_next = ST_SCAN_TAIL;
                end
            end
            ST_SCAN_TAIL:
            begin
                state_next = ST_EXEC_WR;
            end
            ST_EXEC_WR:
            begin
                ram_we     = have_reg;
                ram_waddr  = best_idx_reg;
                ram_wdata  = {1'b0, best_owner_reg, best_prio_reg};
                found_next = have_reg;
                owner_next = have_reg ? FIELD_W'(best_owner_reg) : '0;
                state_next = ST_RESULT;
            end
            ST_RESULT:
            begin
                if (rsp_free)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_next.found = found_reg;
                    rsp_next.owner = owner_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            addr_reg       <= '0;
            rd_pending_reg <= 1'b0;
            rd_idx_reg     <= '0;
            have_reg       <= 1'b0;
            best_idx_reg   <= '0;
            best_prio_reg  <= '0;
            best_owner_reg <= '0;
            edit_prio_reg  <= '0;
            edit_idx_reg   <= '0;
            found_reg      <= 1'b0;
            owner_reg      <= '0;
            rsp_valid_reg  <= 1'b0;
            rsp_reg        <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            addr_reg       <= addr_next;
            rd_pending_reg <= rd_pending_next;
            rd_idx_reg     <= rd_idx_next;
            have_reg       <= have_next;
            best_idx_reg   <= best_idx_next;
            best_prio_reg  <= best_prio_next;
            best_owner_reg <= best_owner_next;
            edit_prio_reg  <= edit_prio_next;
            edit_idx_reg   <= edit_idx_next;
            found_reg      <= found_next;
            owner_reg      <= owner_next;
            rsp_valid_reg  <= rsp_valid_next;
            rsp_reg        <= rsp_next;
        end
    end

`ifndef SYNTHESIS
    a_owner_zero_when_not_found: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp.found) |-> (rsp.owner == '0))
        else $error("owner nonzero on a not-found response");

    a_one_request_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> !req_ready)
        else $error("request taken while another is in progress");

    a_tail_has_read: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN_TAIL) |-> rd_pending_reg)
        else $error("scan tail without the last slot read pending");

    a_winner_freed: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EXEC_WR && have_reg) |-> (ram_we && !ram_wdata[WORD_W-1]))
        else $error("executed task not removed from the table");
`endif

endmodule
